// ===== hdl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// operation and status codes shared by the deque engine and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

	localparam int unsigned KIND_W   = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned VALUE_W  = 32;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam kind_t KIND_PUSH_FRONT = 3'd0;
	localparam kind_t KIND_PUSH_BACK  = 3'd1;
	localparam kind_t KIND_POP_FRONT  = 3'd2;
	localparam kind_t KIND_POP_BACK   = 3'd3;
	localparam kind_t KIND_DUMP_FWD   = 3'd4;
	localparam kind_t KIND_DUMP_REV   = 3'd5;

	// result status codes
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/bounded_deque_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_engine
// bounded double-ended queue of signed 32-bit values kept in a ring buffer
// ----------------------------------------------------------------------------
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------
//   in      | in_valid / in_stall     | kind, value
//   out     | out_valid / out_stall   | value_res, status, last
//
// one item is worked on at a time; the ring buffer is a single memory with a
// registered read, so a pop is accepted, its data is read into rd_data_q and
// then loaded into the output register; a push or any empty/full answer goes
// through ST_RSP to the output register, and a dump reads its elements in
// turn, fetching the next one while the current one goes out
// in_stall is high from the cycle after an accept of a defined code until the
// last result of that item is loaded into the output register
// a result waiting in the output register does not block the next accept
// reset clears the front pointer, the element count and the control state;
// the memory contents are not cleared
//
`default_nettype none

module bounded_deque_engine #(
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input items
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [bde_pkg::KIND_W-1:0]             kind,
	input  wire logic signed [bde_pkg::VALUE_W-1:0]     value,
	// result items
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [bde_pkg::VALUE_W-1:0]          value_res,
	output logic [bde_pkg::STATUS_W-1:0]                status,
	output logic                                        last
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,  // ready for the next item
		ST_RSP  = 3'b010,  // result without memory data waits for the output
		ST_RD   = 3'b100   // read data is in rd_data_q
	} state_t;

	// ring index of base + off, both below DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
	                                              input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	// storage and its registered read port
	logic [bde_pkg::VALUE_W-1:0] ring_mem [DEPTH];
	logic [bde_pkg::VALUE_W-1:0] rd_data_q;

	// control state
	state_t                   state_q,  state_d;
	logic [IDX_W-1:0]         front_q,  front_d;
	logic [CNT_W-1:0]         count_q,  count_d;
	logic [CNT_W-1:0]         dump_i_q, dump_i_d;   // next element of a dump
	logic                     dump_q,   dump_d;     // current item is a dump
	logic                     rev_q,    rev_d;      // dump runs back to front
	bde_pkg::status_t         stat_q,   stat_d;     // status for ST_RSP

	// output register
	logic                     out_valid_q;
	logic [bde_pkg::VALUE_W-1:0] out_value_q;
	bde_pkg::status_t         out_status_q;
	logic                     out_last_q;

	// memory access for this cycle
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;

	// output load for this cycle
	logic                     out_ld;
	logic [bde_pkg::VALUE_W-1:0] ld_value;
	bde_pkg::status_t         ld_status;
	logic                     ld_last;

	logic                     in_acc;
	logic                     out_free;
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         dump_off_n;     // offset of the next dump element
	logic [IDX_W-1:0]         dump_addr;
	logic                     rd_last;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);

	// reverse dumps count down from the back element
	assign dump_off_n = rev_q ? (count_q - CNT_W'(1) - dump_i_q) : dump_i_q;
	assign dump_addr  = ring_add(front_q, dump_off_n[IDX_W-1:0]);
	assign rd_last    = !dump_q || (dump_i_q == count_q);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		dump_i_d  = dump_i_q;
		dump_d    = dump_q;
		rev_d     = rev_q;
		stat_d    = stat_q;
		wr_en     = 1'b0;
		wr_addr   = front_q;
		rd_en     = 1'b0;
		rd_addr   = front_q;
		out_ld    = 1'b0;
		ld_value  = '0;
		ld_status = bde_pkg::STATUS_OK;
		ld_last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (kind) inside
						bde_pkg::KIND_PUSH_FRONT, bde_pkg::KIND_PUSH_BACK: begin
							state_d = ST_RSP;
							if (full) begin
								stat_d = bde_pkg::STATUS_FULL;
							end else begin
								stat_d  = bde_pkg::STATUS_OK;
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (kind == bde_pkg::KIND_PUSH_FRONT) begin
									front_d = (front_q == '0) ? IDX_LAST
									                          : front_q - IDX_W'(1);
									wr_addr = front_d;
								end else begin
									wr_addr = ring_add(front_q, count_q[IDX_W-1:0]);
								end
							end
						end
						bde_pkg::KIND_POP_FRONT, bde_pkg::KIND_POP_BACK: begin
							if (empty) begin
								state_d = ST_RSP;
								stat_d  = bde_pkg::STATUS_EMPTY;
							end else begin
								state_d = ST_RD;
								dump_d  = 1'b0;
								rd_en   = 1'b1;
								count_d = count_q - CNT_W'(1);
								if (kind == bde_pkg::KIND_POP_FRONT) begin
									rd_addr = front_q;
									front_d = (front_q == IDX_LAST) ? '0
									                                : front_q + IDX_W'(1);
								end else begin
									rd_addr = ring_add(front_q, count_d[IDX_W-1:0]);
								end
							end
						end
						bde_pkg::KIND_DUMP_FWD, bde_pkg::KIND_DUMP_REV: begin
							if (empty) begin
								state_d = ST_RSP;
								stat_d  = bde_pkg::STATUS_EMPTY;
							end else begin
								state_d  = ST_RD;
								dump_d   = 1'b1;
								rev_d    = (kind == bde_pkg::KIND_DUMP_REV);
								dump_i_d = CNT_W'(1);
								rd_en    = 1'b1;
								// first element: front, or back for reverse
								rd_addr  = (kind == bde_pkg::KIND_DUMP_REV)
								         ? ring_add(front_q, IDX_W'(count_q - CNT_W'(1)))
								         : front_q;
							end
						end
						default: begin
							// unused codes are dropped
						end
					endcase
				end
			end
			ST_RSP: begin
				if (out_free) begin
					out_ld    = 1'b1;
					ld_status = stat_q;
					state_d   = ST_IDLE;
				end
			end
			ST_RD: begin
				if (out_free) begin
					out_ld   = 1'b1;
					ld_value = rd_data_q;
					ld_last  = rd_last;
					if (rd_last) begin
						state_d = ST_IDLE;
					end else begin
						// fetch the next dump element while this one goes out
						rd_en    = 1'b1;
						rd_addr  = dump_addr;
						dump_i_d = dump_i_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ring buffer memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dump_i_q    <= '0;
			dump_q      <= 1'b0;
			rev_q       <= 1'b0;
			stat_q      <= bde_pkg::STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			dump_i_q <= dump_i_d;
			dump_q   <= dump_d;
			rev_q    <= rev_d;
			stat_q   <= stat_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_value_q  <= ld_value;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = out_value_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/bde_chk.sv =====
// ----------------------------------------------------------------------------
// bde_chk
// port-level checks for the deque engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bde_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic [bde_pkg::KIND_W-1:0]         kind,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [bde_pkg::VALUE_W-1:0]        value_res,
	input wire logic [bde_pkg::STATUS_W-1:0]       status,
	input wire logic                               last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_res) && $stable(status)
		&& $stable(last))
		else $error("stalled result changed");

	// only defined status codes are shown
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == bde_pkg::STATUS_OK || status == bde_pkg::STATUS_EMPTY
		|| status == bde_pkg::STATUS_FULL))
		else $error("undefined status code");

	// empty and full answers are single results without a value
	a_refusal_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bde_pkg::STATUS_OK |-> last && value_res == '0)
		else $error("empty or full result is malformed");

	// a valid operation occupies the engine in the following cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind <= bde_pkg::KIND_DUMP_REV |=> in_stall)
		else $error("second item accepted while one is in flight");

endmodule

bind bounded_deque_engine bde_chk u_bde_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value_res (value_res),
	.status    (status),
	.last      (last)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bounded deque engine: a queued driver feeds
// push, pop and dump operations, a shadow deque predicts every result, and a
// monitor compares each result field by field while both sides idle at random
// ----------------------------------------------------------------------------

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH      = 32;
	localparam int unsigned RANDOM_OPS = 320;   // random items that do something
	localparam int unsigned TAIL_OPS   = 40;    // closing items sent without idling
	localparam int unsigned DRAIN_WAIT = 10;    // cycles to watch after the last result

	// the two operation codes that the block must ignore
	localparam bde_pkg::kind_t KIND_UNUSED_LO = 3'd6;
	localparam bde_pkg::kind_t KIND_UNUSED_HI = 3'd7;

	typedef struct {
		bde_pkg::kind_t                       kind;
		logic signed [bde_pkg::VALUE_W-1:0]   value;
	} deque_op_t;

	typedef struct {
		logic signed [bde_pkg::VALUE_W-1:0]   value_res;
		bde_pkg::status_t                     status;
		logic                                 last;
	} deque_reply_t;

	// clock, reset and block ports
	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_stall;
	bde_pkg::kind_t                       kind      = bde_pkg::KIND_PUSH_FRONT;
	logic signed [bde_pkg::VALUE_W-1:0]   value     = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [bde_pkg::VALUE_W-1:0]   value_res;
	bde_pkg::status_t                     status;
	logic                                 last;

	// operations waiting to be sent and results waiting to arrive
	deque_op_t      pending_ops[$];
	deque_reply_t   expected_replies[$];

	// shadow copy of the deque
	logic signed [bde_pkg::VALUE_W-1:0]   model_store[DEPTH];
	int unsigned                          model_front = 0;
	int unsigned                          model_count = 0;

	int unsigned   ops_total  = 0;
	int unsigned   sent_count = 0;
	int unsigned   errors     = 0;

	// idle bookkeeping for each side: length of the current burst and of the
	// current stretch without idling
	int   send_gap    = 0;
	int   send_quiet  = 0;
	int   stall_gap   = 0;
	int   stall_quiet = 0;

	bounded_deque_engine #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_res (value_res),
		.status    (status),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decide whether a side idles this cycle; idling comes in bursts of random
	// length, and now and then a long stretch goes by with no idling at all
	function automatic bit take_pause(inout int gap, inout int quiet, input bit tail);
		if (tail) begin
			gap = 0;
			return 1'b0;
		end
		if (gap > 0) begin
			gap--;
			return 1'b1;
		end
		if (quiet > 0) begin
			quiet--;
			return 1'b0;
		end
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				gap = $urandom_range(0, 7);
				return 1'b1;
			end
			4: begin
				quiet = $urandom_range(20, 80);
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// apply one accepted operation to the shadow deque and queue the results
	// that it must produce
	function automatic void deque_model_apply(bde_pkg::kind_t op,
	                                          logic signed [bde_pkg::VALUE_W-1:0] data);
		deque_reply_t   r;
		int unsigned    pos;
		r.value_res = '0;
		r.status    = bde_pkg::STATUS_OK;
		r.last      = 1'b1;
		case (op)
			bde_pkg::KIND_PUSH_FRONT, bde_pkg::KIND_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					// refused, nothing stored
					r.status = bde_pkg::STATUS_FULL;
				end else begin
					if (op == bde_pkg::KIND_PUSH_FRONT) begin
						model_front = (model_front + DEPTH - 1) % DEPTH;
						pos = model_front;
					end else begin
						pos = (model_front + model_count) % DEPTH;
					end
					model_store[pos] = data;
					model_count++;
				end
				expected_replies.push_back(r);
			end
			bde_pkg::KIND_POP_FRONT, bde_pkg::KIND_POP_BACK: begin
				if (model_count == 0) begin
					r.status = bde_pkg::STATUS_EMPTY;
				end else if (op == bde_pkg::KIND_POP_FRONT) begin
					r.value_res = model_store[model_front];
					model_front = (model_front + 1) % DEPTH;
					model_count--;
				end else begin
					r.value_res = model_store[(model_front + model_count - 1) % DEPTH];
					model_count--;
				end
				expected_replies.push_back(r);
			end
			bde_pkg::KIND_DUMP_FWD, bde_pkg::KIND_DUMP_REV: begin
				if (model_count == 0) begin
					r.status = bde_pkg::STATUS_EMPTY;
					expected_replies.push_back(r);
				end else begin
					// one result per element, deque left as it is
					for (int unsigned i = 0; i < model_count; i++) begin
						pos = (op == bde_pkg::KIND_DUMP_FWD) ? i : model_count - 1 - i;
						r.value_res = model_store[(model_front + pos) % DEPTH];
						r.last      = (i + 1 == model_count);
						expected_replies.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic queue_op(bde_pkg::kind_t op, logic signed [bde_pkg::VALUE_W-1:0] data);
		deque_op_t   item;
		item.kind  = op;
		item.value = data;
		pending_ops.push_back(item);
	endtask

	// driver: holds an item until it is taken, predicts it on the accepting
	// edge, then either idles or presents the next pending item
	always @(posedge clk or negedge arst_n) begin
		deque_op_t   item;
		logic        busy;
		bit          tail;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			kind       <= bde_pkg::KIND_PUSH_FRONT;
			value      <= '0;
			sent_count <= 0;
		end else begin
			busy = in_valid;
			tail = (sent_count + TAIL_OPS >= ops_total);
			if (in_valid && !in_stall) begin
				deque_model_apply(kind, value);
				sent_count <= sent_count + 1;
				busy = 1'b0;
			end
			// a held item keeps valid and payload untouched
			if (!busy) begin
				if (pending_ops.size() != 0
					&& !take_pause(send_gap, send_quiet, tail)) begin
					item = pending_ops.pop_front();
					kind     <= item.kind;
					value    <= item.value;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every accepted result against the oldest expectation
	// and drives random stall bursts toward the block
	always @(posedge clk or negedge arst_n) begin
		deque_reply_t   want;
		bit             tail;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			tail = (sent_count + TAIL_OPS >= ops_total);
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: result with nothing expected, actual %0d %0d %0d",
						$realtime, value_res, status, last);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (value_res !== want.value_res) begin
						$display("%0t: value_res mismatch, expected %0d, actual %0d",
							$realtime, want.value_res, value_res);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$realtime, want.status, status);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch, expected %0d, actual %0d",
							$realtime, want.last, last);
						errors++;
					end
				end
			end
			out_stall <= take_pause(stall_gap, stall_quiet, tail);
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic signed [bde_pkg::VALUE_W-1:0]   corner_vals[4];
		logic signed [bde_pkg::VALUE_W-1:0]   data;
		int unsigned                          useful;
		int unsigned                          run;
		int unsigned                          push_pct;
		int unsigned                          roll;
		corner_vals[0] = 32'sh7fff_ffff;
		corner_vals[1] = 32'sh8000_0000;
		corner_vals[2] = '0;
		corner_vals[3] = -32'sd1;

		// empty deque: pops and dumps on nothing, then codes that do nothing
		queue_op(bde_pkg::KIND_POP_FRONT, 32'sd5);
		queue_op(bde_pkg::KIND_POP_BACK, -32'sd5);
		queue_op(bde_pkg::KIND_DUMP_FWD, 32'sd7);
		queue_op(bde_pkg::KIND_DUMP_REV, 32'sd9);
		queue_op(KIND_UNUSED_LO, 32'sh1234_5678);
		queue_op(KIND_UNUSED_HI, 32'sh8765_4321);
		// single element taken from either end leaves the deque empty
		queue_op(bde_pkg::KIND_PUSH_BACK, 32'sh7fff_ffff);
		queue_op(bde_pkg::KIND_POP_FRONT, '0);
		queue_op(bde_pkg::KIND_DUMP_FWD, '0);
		queue_op(bde_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
		queue_op(bde_pkg::KIND_POP_BACK, '0);
		queue_op(bde_pkg::KIND_POP_FRONT, '0);
		// a few elements from both ends, dumped both ways, then drained
		queue_op(bde_pkg::KIND_PUSH_BACK, -32'sd1);
		queue_op(bde_pkg::KIND_PUSH_FRONT, '0);
		queue_op(bde_pkg::KIND_PUSH_BACK, 32'sd1);
		queue_op(bde_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
		queue_op(bde_pkg::KIND_DUMP_FWD, '0);
		queue_op(bde_pkg::KIND_DUMP_REV, '0);
		queue_op(bde_pkg::KIND_POP_FRONT, '0);
		queue_op(bde_pkg::KIND_POP_BACK, '0);
		queue_op(bde_pkg::KIND_POP_FRONT, '0);
		queue_op(bde_pkg::KIND_POP_BACK, '0);
		queue_op(bde_pkg::KIND_POP_BACK, '0);

		// random runs that lean toward filling, draining or neither, so the
		// deque reaches full and empty often and the ring wraps both ways
		useful = 0;
		while (useful < RANDOM_OPS) begin
			run = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			repeat (run) begin
				roll = $urandom_range(0, 99);
				data = ($urandom_range(0, 7) == 0) ? corner_vals[$urandom_range(0, 3)]
					: $urandom();
				if (roll < 3) begin
					queue_op(bde_pkg::kind_t'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
						data);
				end else begin
					if (roll < 11) begin
						queue_op($urandom_range(0, 1) ? bde_pkg::KIND_DUMP_FWD
							: bde_pkg::KIND_DUMP_REV, data);
					end else if ($urandom_range(0, 99) < push_pct) begin
						queue_op($urandom_range(0, 1) ? bde_pkg::KIND_PUSH_FRONT
							: bde_pkg::KIND_PUSH_BACK, data);
					end else begin
						queue_op($urandom_range(0, 1) ? bde_pkg::KIND_POP_FRONT
							: bde_pkg::KIND_POP_BACK, data);
					end
					useful++;
				end
			end
		end
		ops_total = pending_ops.size();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// every item taken and every result seen, then a short watch for strays
		while (sent_count != ops_total || expected_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// hard limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout, %0d items sent of %0d, %0d results outstanding",
			sent_count, ops_total, expected_replies.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
